// ===== design/bloom_filter_insert_query_assert.svh =====
// Assertion macros for the bloom filter block.
`ifndef BLOOM_FILTER_INSERT_QUERY_ASSERT_SVH
`define BLOOM_FILTER_INSERT_QUERY_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BFIQ_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfiq: implication violated");

// Next-cycle implication, checked out of reset.
`define BFIQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfiq: next-cycle check violated");

`endif

// ===== design/bfiq_pkg.sv =====
// Shared constants, types and helpers of the bloom filter block.
package bfiq_pkg;

  localparam int MAX_BITS          = 65536;
  localparam int MAX_HASHES        = 4;
  localparam int MAX_ELEMENT_BYTES = 1024;
  localparam int ADDR_W            = $clog2(MAX_BITS);
  localparam int LEN_W             = $clog2(MAX_ELEMENT_BYTES) + 1;
  localparam int HIDX_W            = 2;
  localparam int MOD_W             = 17;

  localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2  = 32'h1b873593;
  localparam logic [31:0] MIX_ADD = 32'he6546b64;
  localparam logic [31:0] FIN_C1  = 32'h85ebca6b;
  localparam logic [31:0] FIN_C2  = 32'hc2b2ae35;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_CHECK = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] CFG_HASH_COUNT = 3'd0;
  localparam logic [2:0] CFG_BITMAP     = 3'd1;
  localparam logic [2:0] CFG_SEED0      = 3'd2;
  localparam logic [2:0] CFG_SEED1      = 3'd3;
  localparam logic [2:0] CFG_SEED2      = 3'd4;
  localparam logic [2:0] CFG_SEED3      = 3'd5;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MIX1, S_MIX2, S_UPD, S_FIN0, S_FIN1, S_FIN2,
    S_DIV, S_RD, S_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } mod_ctl_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

endpackage

// ===== design/bfiq_mul.sv =====
// Shared 32x32 multiplier, low word of product registered.
module bfiq_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p_r
);
  logic [31:0] prod;

  assign prod = a * b;

  always_ff @(posedge clk) begin
    p_r <= prod;
  end
endmodule

// ===== design/bfiq_mod.sv =====
// Restoring bit-serial remainder unit, one dividend bit per cycle.
module bfiq_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [31:0]                 dividend,
  input  logic [bfiq_pkg::MOD_W-1:0]  divisor,
  output logic                        done_r,
  output logic [bfiq_pkg::MOD_W-1:0]  rem_r
);
  import bfiq_pkg::*;

  logic [31:0]      dvd_r;
  logic [MOD_W-1:0] dvs_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic [MOD_W:0]   trial;
  logic [MOD_W:0]   diff;

  assign trial = {rem_r, dvd_r[31]};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[30:0], 1'b0};
        rem_r <= diff[MOD_W] ? trial[MOD_W-1:0] : diff[MOD_W-1:0];
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== design/bloom_filter_insert_query.sv =====
// A hashed word goes through the shared multiplier in S_MIX1 and S_MIX2, then S_UPD; a dropped word is not hashed.
// A last word then runs each probe through the multiplies (S_FIN0 to S_FIN2), the remainder unit
// (S_DIV), a bitmap read (S_RD) and write (S_WR), and S_DONE posts the result word.
// Input is taken only in S_IDLE, so the block handles one word at a time.
// Reset and the clear command sweep the whole bitmap, one bit per cycle, no input taken.
// Reset loads hash seeds, registers to defaults and zeroes the counters.
module bloom_filter_insert_query (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // data_word[31:0], bytes_valid[34:32], zero pad
  input  logic [1:0]  in_tuser,   // command[1:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // was_present[0], added_total[32:1],
                                  // collision_total[64:33], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import bfiq_pkg::*;

  `include "bloom_filter_insert_query_assert.svh"

  state_t state_r, state_nxt;
  logic [1:0]        cmd_r, cmd_nxt;
  logic [31:0]       word_r, word_nxt;
  logic [2:0]        nb_r, nb_nxt;
  logic              last_r, last_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              open_r, open_nxt;
  logic [31:0]       h_r [MAX_HASHES];
  logic [31:0]       h_nxt [MAX_HASHES];
  logic [31:0]       seed_r [4];
  logic [31:0]       seed_nxt [4];
  logic [2:0]        hcnt_r, hcnt_nxt;
  logic [16:0]       bbits_r, bbits_nxt;
  logic [HIDX_W-1:0] probe_r, probe_nxt;
  logic              hit_r, hit_nxt;
  logic [31:0]       added_r, added_nxt;
  logic [31:0]       coll_r, coll_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_present_r, out_present_nxt;
  logic [31:0]       out_added_r, out_added_nxt;
  logic [31:0]       out_coll_r, out_coll_nxt;

  logic [31:0]       mul_a, mul_b, mul_p;
  logic              mod_start;
  logic              mod_done;
  logic [31:0]       mod_dividend;
  logic [MOD_W-1:0]  modulus;
  logic [MOD_W-1:0]  mod_rem;
  logic [HIDX_W-1:0] probe_last;

  logic              mem [MAX_BITS];
  logic              mem_q_r;
  logic              mem_we, mem_wd;
  logic [ADDR_W-1:0] mem_waddr;

  logic [2:0]        in_nb;
  logic [31:0]       in_mask;
  logic [LEN_W:0]    len_sum;
  logic [31:0]       t, k;

  bfiq_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));

  bfiq_mod u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .dividend(mod_dividend),
    .divisor(modulus), .done_r(mod_done), .rem_r(mod_rem)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_coll_r, out_added_r, out_present_r};

  always_comb begin
    if (hcnt_r == 3'd0) probe_last = '0;
    else if (hcnt_r > 3'(MAX_HASHES)) probe_last = HIDX_W'(MAX_HASHES - 1);
    else probe_last = HIDX_W'(hcnt_r - 3'd1);
    if (bbits_r == 17'd0) modulus = 17'd1;
    else if (bbits_r > 17'(MAX_BITS)) modulus = 17'(MAX_BITS);
    else modulus = bbits_r;
  end

  always_comb begin
    in_nb   = (in_tdata[34:32] > 3'd4) ? 3'd4 : in_tdata[34:32];
    unique case (in_nb)
      3'd0:    in_mask = 32'h0000_0000;
      3'd1:    in_mask = 32'h0000_00ff;
      3'd2:    in_mask = 32'h0000_ffff;
      3'd3:    in_mask = 32'h00ff_ffff;
      default: in_mask = 32'hffff_ffff;
    endcase
    len_sum = {1'b0, len_r} + {{(LEN_W-2){1'b0}}, in_nb};
  end

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    word_nxt        = word_r;
    nb_nxt          = nb_r;
    last_nxt        = last_r;
    len_nxt         = len_r;
    open_nxt        = open_r;
    h_nxt           = h_r;
    seed_nxt        = seed_r;
    hcnt_nxt        = hcnt_r;
    bbits_nxt       = bbits_r;
    probe_nxt       = probe_r;
    hit_nxt         = hit_r;
    added_nxt       = added_r;
    coll_nxt        = coll_r;
    clr_nxt         = clr_r;
    out_present_nxt = out_present_r;
    out_added_nxt   = out_added_r;
    out_coll_nxt    = out_coll_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    mul_a           = word_r;
    mul_b           = MIX_C1;
    mod_start       = 1'b0;
    mod_dividend    = mul_p ^ (mul_p >> 16);
    mem_we          = 1'b0;
    mem_wd          = 1'b0;
    mem_waddr       = mod_rem[ADDR_W-1:0];
    t               = h_r[probe_r] ^ {{(32-LEN_W){1'b0}}, len_r};
    k               = mul_p;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HASH_COUNT: hcnt_nxt = cfg_data[2:0];
        CFG_BITMAP:     bbits_nxt = cfg_data[16:0];
        CFG_SEED0, CFG_SEED1, CFG_SEED2, CFG_SEED3: begin
          seed_nxt[cfg_index[1:0] - 2'd2] = cfg_data;
          if (!open_r) h_nxt[cfg_index[1:0] - 2'd2] = cfg_data;
        end
        default: ;
      endcase
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == {ADDR_W{1'b1}}) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          probe_nxt = '0;
          hit_nxt   = 1'b1;
          unique case (in_tuser)
            CMD_CLEAR: begin
              added_nxt = '0;
              coll_nxt  = '0;
              h_nxt     = seed_r;
              len_nxt   = '0;
              open_nxt  = 1'b0;
              clr_nxt   = '0;
              state_nxt = S_CLEAR;
            end
            CMD_ADD, CMD_CHECK: begin
              open_nxt = 1'b1;
              cmd_nxt  = in_tuser;
              word_nxt = in_tdata[31:0] & in_mask;
              nb_nxt   = in_nb;
              last_nxt = in_tlast;
              if ((in_tlast || in_nb == 3'd4) && in_nb != 3'd0 &&
                  len_sum <= (LEN_W+1)'(MAX_ELEMENT_BYTES)) begin
                state_nxt = S_MIX1;
              end else if (in_tlast) begin
                state_nxt = S_FIN0;
              end
            end
            default: ;
          endcase
        end
      end
      S_MIX1: begin
        mul_a     = word_r;
        mul_b     = MIX_C1;
        state_nxt = S_MIX2;
      end
      S_MIX2: begin
        mul_a     = rotl(mul_p, 15);
        mul_b     = MIX_C2;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        for (int i = 0; i < MAX_HASHES; i++) begin
          if (nb_r == 3'd4) begin
            h_nxt[i] = (rotl(h_r[i] ^ k, 13) << 2) + rotl(h_r[i] ^ k, 13) + MIX_ADD;
          end else begin
            h_nxt[i] = h_r[i] ^ k;
          end
        end
        len_nxt   = len_r + LEN_W'(nb_r);
        state_nxt = last_r ? S_FIN0 : S_IDLE;
      end
      S_FIN0: begin
        mul_a     = t ^ (t >> 16);
        mul_b     = FIN_C1;
        state_nxt = S_FIN1;
      end
      S_FIN1: begin
        mul_a     = mul_p ^ (mul_p >> 13);
        mul_b     = FIN_C2;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        mod_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (mod_done) state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        if (!mem_q_r) begin
          hit_nxt = 1'b0;
          if (cmd_r == CMD_ADD) begin
            mem_we = 1'b1;
            mem_wd = 1'b1;
          end
        end
        if (probe_r == probe_last) begin
          state_nxt = S_DONE;
        end else begin
          probe_nxt = probe_r + 1'b1;
          state_nxt = S_FIN0;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt   = 1'b1;
          out_present_nxt = hit_r;
          out_added_nxt   = added_r;
          out_coll_nxt    = coll_r;
          if (cmd_r == CMD_ADD) begin
            if (hit_r) begin
              coll_nxt     = coll_r + 32'd1;
              out_coll_nxt = coll_r + 32'd1;
            end else begin
              added_nxt     = added_r + 32'd1;
              out_added_nxt = added_r + 32'd1;
            end
          end
          h_nxt     = seed_r;
          len_nxt   = '0;
          open_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wd;
    mem_q_r <= mem[mod_rem[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      len_r       <= '0;
      open_r      <= 1'b0;
      hcnt_r      <= 3'd4;
      bbits_r     <= 17'(MAX_BITS);
      seed_r[0]   <= 32'd0;
      seed_r[1]   <= 32'd1;
      seed_r[2]   <= 32'd2;
      seed_r[3]   <= 32'd3;
      h_r[0]      <= 32'd0;
      h_r[1]      <= 32'd1;
      h_r[2]      <= 32'd2;
      h_r[3]      <= 32'd3;
      added_r     <= '0;
      coll_r      <= '0;
      probe_r     <= '0;
      hit_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      len_r       <= len_nxt;
      open_r      <= open_nxt;
      hcnt_r      <= hcnt_nxt;
      bbits_r     <= bbits_nxt;
      seed_r      <= seed_nxt;
      h_r         <= h_nxt;
      added_r     <= added_nxt;
      coll_r      <= coll_nxt;
      probe_r     <= probe_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    word_r        <= word_nxt;
    nb_r          <= nb_nxt;
    last_r        <= last_nxt;
    out_present_r <= out_present_nxt;
    out_added_r   <= out_added_nxt;
    out_coll_r    <= out_coll_nxt;
  end

  `BFIQ_ASSERT_IMPLY(a_probe_range, state_r == S_FIN0, probe_r <= probe_last)
  `BFIQ_ASSERT_IMPLY(a_mod_done_in_div, mod_done, state_r == S_DIV)
  `BFIQ_ASSERT_NEXT(a_done_blocks_input, state_r == S_WR && probe_r == probe_last, !in_tready)
  `BFIQ_ASSERT_IMPLY(a_no_write_on_check, mem_we && mem_wd, cmd_r == CMD_ADD && state_r == S_WR)

endmodule

// ===== tb/bfiq_checker.sv =====
// Checker of the bloom filter block: predicts each result word and compares it.
module bfiq_checker
  import bfiq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic        hit;
    logic [31:0] added;
    logic [31:0] collided;
  } answer_t;

  answer_t     answers[$];
  bit          bitmap[MAX_BITS];
  logic [31:0] hashes[MAX_HASHES];
  logic [31:0] seeds[4];
  logic [2:0]  probe_cfg;
  logic [16:0] size_cfg;
  int          elem_len;
  bit          elem_open;
  logic [31:0] adds, hits;

  initial pending = 0;

  function automatic logic [31:0] rot(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] scramble(input logic [31:0] k);
    return rot(k * MIX_C1, 15) * MIX_C2;
  endfunction

  function automatic logic [31:0] avalanche(input logic [31:0] h);
    h = h ^ (h >> 16);
    h = h * FIN_C1;
    h = h ^ (h >> 13);
    h = h * FIN_C2;
    return h ^ (h >> 16);
  endfunction

  function automatic void reseed();
    for (int i = 0; i < MAX_HASHES; i++) hashes[i] = seeds[i];
    elem_len = 0;
    elem_open = 0;
  endfunction

  function automatic void wipe();
    foreach (bitmap[i]) bitmap[i] = 0;
    adds = '0;
    hits = '0;
    reseed();
  endfunction

  function automatic void absorb(input logic [1:0] cmd, input logic [31:0] w,
                                 input int nb, input bit last);
    int probes, modulus, found;
    logic [31:0] h, k, pos;
    answer_t a;
    if (cmd == CMD_CLEAR) begin
      wipe();
      return;
    end
    if (cmd != CMD_ADD && cmd != CMD_CHECK) return;
    if (nb > 4) nb = 4;
    elem_open = 1;
    if ((last || nb == 4) && elem_len + nb <= MAX_ELEMENT_BYTES) begin
      if (nb == 4) begin
        for (int i = 0; i < MAX_HASHES; i++) begin
          h = rot(hashes[i] ^ scramble(w), 13);
          hashes[i] = h * 5 + MIX_ADD;
        end
      end else if (nb > 0) begin
        k = scramble(w & ((32'd1 << (8 * nb)) - 1));
        for (int i = 0; i < MAX_HASHES; i++) hashes[i] ^= k;
      end
      elem_len += nb;
    end
    if (!last) return;
    probes = (probe_cfg == 0) ? 1 : (probe_cfg > MAX_HASHES ? MAX_HASHES : probe_cfg);
    modulus = (size_cfg == 0) ? 1 : (size_cfg > MAX_BITS ? MAX_BITS : size_cfg);
    found = 0;
    for (int i = 0; i < probes; i++) begin
      pos = avalanche(hashes[i] ^ elem_len) % modulus;
      if (bitmap[pos]) found++;
      else if (cmd == CMD_ADD) bitmap[pos] = 1;
    end
    a.hit = (found == probes);
    if (cmd == CMD_ADD) begin
      if (a.hit) hits++;
      else adds++;
    end
    a.added = adds;
    a.collided = hits;
    answers.push_back(a);
    reseed();
  endfunction

  always @(posedge clk) begin
    answer_t a;
    if (!rst_n) begin
      probe_cfg <= 3'd4;
      size_cfg <= 17'd65536;
      seeds[0] = 0; seeds[1] = 1; seeds[2] = 2; seeds[3] = 3;
      wipe();
      answers.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HASH_COUNT: probe_cfg <= cfg_data[2:0];
          CFG_BITMAP:     size_cfg <= cfg_data[16:0];
          CFG_SEED0, CFG_SEED1, CFG_SEED2, CFG_SEED3: begin
            seeds[cfg_index - CFG_SEED0] = cfg_data;
            if (!elem_open) hashes[cfg_index - CFG_SEED0] = cfg_data;
          end
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        absorb(in_tuser, in_tdata[31:0], int'(in_tdata[34:32]), in_tlast);
      if (out_tvalid && out_tready) begin
        if (answers.size() == 0) begin
          $error("result word with no expectation: %h", out_tdata);
          errors <= errors + 1;
        end else begin
          a = answers.pop_front();
          if (out_tdata[0] !== a.hit || out_tdata[32:1] !== a.added ||
              out_tdata[64:33] !== a.collided || out_tdata[71:65] !== '0) begin
            if (out_tdata[0] !== a.hit)
              $error("was_present: expected %0d, got %0d", a.hit, out_tdata[0]);
            if (out_tdata[32:1] !== a.added)
              $error("added_total: expected %0d, got %0d", a.added, out_tdata[32:1]);
            if (out_tdata[64:33] !== a.collided)
              $error("collision_total: expected %0d, got %0d",
                     a.collided, out_tdata[64:33]);
            if (out_tdata[71:65] !== '0)
              $error("pad: expected 0, got %h", out_tdata[71:65]);
            errors <= errors + 1;
          end
        end
      end
    end
    pending = answers.size();
  end

endmodule

// ===== tb/tb.sv =====
// Top of the bloom filter testbench: clock, reset, stimulus and verdict.
module tb;
  import bfiq_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = CMD_ADD;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [71:0] out_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_HASH_COUNT;
  logic [31:0] cfg_data = '0;
  int          errors, pending;
  bit          calm = 0;
  bit          stall_go = 0;
  bit          stall_taken = 0;
  int          hold = 0;

  logic [31:0] lib_words[32][8];
  int          lib_len[32];
  int          lib_tail[32];
  int          lib_fill = 0;

  localparam logic [1:0] CMD_NONE = 2'd3;

  always #4 clk = ~clk;

  bloom_filter_insert_query dut (.*);

  bfiq_checker chk (.*);

  // receiver: random backpressure plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else if (stall_go && !stall_taken) begin
      stall_taken <= 1;
      hold <= 3000;
      out_tready <= 0;
    end else if (hold > 0) begin
      hold <= hold - 1;
      out_tready <= 0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 34);
    end
  end

  task automatic send(input logic [1:0] cmd, input logic [31:0] w,
                      input logic [2:0] nb, input bit last);
    if (!calm && $urandom_range(99) < 34) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= cmd;
    in_tdata <= {5'd0, nb, w};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop sending, then wait until every result is out and the block is idle
  task automatic settle();
    in_tvalid <= 0;
    repeat (2) @(posedge clk);
    wait (pending == 0 && in_tready);
    repeat (200) @(posedge clk);
  endtask

  task automatic cfg_set(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [2:0] hc, input logic [16:0] bm,
                           input logic [31:0] s0, input logic [31:0] s1,
                           input logic [31:0] s2, input logic [31:0] s3);
    settle();
    cfg_set(CFG_HASH_COUNT, {29'd0, hc});
    cfg_set(CFG_BITMAP, {15'd0, bm});
    cfg_set(CFG_SEED0, s0);
    cfg_set(CFG_SEED1, s1);
    cfg_set(CFG_SEED2, s2);
    cfg_set(CFG_SEED3, s3);
    cfg_valid <= 0;
  endtask

  // random element, remembered for later replay
  task automatic element(input logic [1:0] cmd);
    int n, slot;
    logic [2:0] tail;
    n = $urandom_range(1, 6);
    tail = 3'($urandom_range(0, 7));
    slot = lib_fill % 32;
    for (int i = 0; i < n; i++) begin
      lib_words[slot][i] = $urandom;
      send((i == n - 1) ? cmd : 2'($urandom_range(0, 1)), lib_words[slot][i],
           (i == n - 1) ? tail : 3'd4, i == n - 1);
    end
    lib_len[slot] = n;
    lib_tail[slot] = int'(tail);
    lib_fill++;
  endtask

  task automatic replay(input logic [1:0] cmd);
    int slot;
    if (lib_fill == 0) return;
    slot = $urandom_range(0, (lib_fill < 32 ? lib_fill : 32) - 1);
    for (int i = 0; i < lib_len[slot]; i++)
      send((i == lib_len[slot] - 1) ? cmd : CMD_CHECK, lib_words[slot][i],
           (i == lib_len[slot] - 1) ? 3'(lib_tail[slot]) : 3'd4, i == lib_len[slot] - 1);
  endtask

  task automatic random_run(input int words);
    int r, start;
    start = 0;
    while (start < words) begin
      r = $urandom_range(99);
      if (r < 45) element(2'($urandom_range(0, 1)));
      else if (r < 85) replay(2'($urandom_range(0, 1)));
      else if (r < 90) send(CMD_NONE, $urandom, 3'($urandom), 1'($urandom_range(0, 1)));
      else if (r < 96) begin
        // dropped partial word in front of an element
        send(CMD_ADD, $urandom, 3'($urandom_range(0, 3)), 0);
        element(CMD_ADD);
      end else element(CMD_CHECK);
      start += 4;
    end
  endtask

  initial begin
    #(8 * 4000000);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // directed: defaults
    send(CMD_ADD, 32'h0, 3'd0, 1);
    send(CMD_ADD, 32'h0, 3'd0, 1);
    send(CMD_ADD, 32'hffffffff, 3'd4, 1);
    send(CMD_CHECK, 32'hffffffff, 3'd4, 1);
    send(CMD_ADD, 32'h12345678, 3'd4, 0);
    send(CMD_ADD, 32'hdeadbeef, 3'd1, 0);
    send(CMD_CHECK, 32'hcafef00d, 3'd3, 1);
    send(CMD_ADD, 32'hcafef00d, 3'd7, 1);
    send(CMD_CHECK, 32'hcafef00d, 3'd4, 1);
    send(CMD_CHECK, 32'h00abcdef, 3'd2, 1);
    send(CMD_NONE, 32'h55555555, 3'd4, 1);
    send(CMD_ADD, 32'haaaaaaaa, 3'd4, 0);
    send(CMD_CLEAR, 32'h0, 3'd0, 0);
    send(CMD_CHECK, 32'hffffffff, 3'd4, 1);
    send(CMD_ADD, 32'h11111111, 3'd5, 1);
    send(CMD_ADD, 32'h11111111, 3'd6, 1);

    // element past the length limit
    for (int i = 0; i < 258; i++) send(CMD_ADD, $urandom, 3'd4, 0);
    send(CMD_ADD, 32'h87654321, 3'd3, 1);

    configure(3'd0, 17'd0, 32'h0, 32'hffffffff, 32'h0, 32'hffffffff);
    random_run(30);
    configure(3'd7, 17'h1ffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    random_run(40);
    configure(3'd4, 17'd65536, $urandom, $urandom, $urandom, $urandom);
    random_run(80);

    // sender pause until drained, then a long receiver hold-off
    settle();
    stall_go <= 1;
    random_run(60);

    configure(3'($urandom_range(1, 4)), 17'd64, $urandom, $urandom, $urandom, $urandom);
    calm <= 1;
    random_run(80);
    calm <= 0;
    send(CMD_CLEAR, $urandom, 3'($urandom), 1);
    configure(3'd2, 17'($urandom_range(8, 300)), $urandom, $urandom, $urandom, $urandom);
    random_run(90);

    settle();
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
